### src/vlda_pkg.sv
// Shared types, constants and helper functions of the voxel label downsampler.
package vlda_pkg;

    localparam int unsigned LAT_XY      = 96;
    localparam int unsigned LAT_Z       = 48;
    localparam int unsigned SRC_MAX     = 1024;
    localparam int unsigned LAT_DEPTH   = LAT_XY * LAT_XY * LAT_Z;
    localparam int unsigned LAT_AW      = $clog2(LAT_DEPTH);
    localparam int unsigned PAL_DEPTH   = 256;

    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_CELL  = 2'd1,
        ACT_PAL   = 2'd2,
        ACT_EMIT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_PAL_SZ = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [1:0] action;
        logic       room_valid;
        logic [7:0] room_id;
        logic [7:0] palette_index;
        logic [7:0] color_red;
        logic [7:0] color_green;
        logic [7:0] color_blue;
        logic [7:0] color_alpha;
    } t_in_item;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
        logic       last_pixel;
    } t_out_item;

    // request to the shared multiply-add unit: res = a * b + c
    typedef struct packed {
        logic        en;
        logic [12:0] a;
        logic [6:0]  b;
        logic [6:0]  c;
    } t_mac_req;

    // control of one axis block tracker
    typedef struct packed {
        logic init;
        logic step;
    } t_axis_ctl;

    // number of tiles across: ceil(sqrt(lz))
    function automatic logic [2:0] f_tiles_x(input logic [5:0] lz);
        logic [2:0] t;
        t = 3'd1;
        for (int k = 1; k < 7; k++) begin
            if (k * k < int'(lz)) t = 3'(k + 1);
        end
        return t;
    endfunction

    // number of tiles down: ceil(lz / tx)
    function automatic logic [2:0] f_tiles_y(input logic [5:0] lz, input logic [2:0] tx);
        logic [2:0] t;
        t = 3'd1;
        for (int k = 1; k < 7; k++) begin
            if (k * int'(tx) < int'(lz)) t = 3'(k + 1);
        end
        return t;
    endfunction

endpackage

### src/vlda_if.sv
// Valid/ready channel interfaces for input items and emitted pixels.
interface vlda_in_if;
    logic                 valid;
    logic                 ready;
    vlda_pkg::t_in_item   item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface vlda_out_if;
    logic                 valid;
    logic                 ready;
    vlda_pkg::t_out_item  item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### src/voxel_label_downsample_atlas.sv
// Top level: sequencer, lattice and palette stores of the voxel label downsampler.
// Source cell: two passes through the shared multiply-add unit, then a read-modify-write
//   of the lattice store. Palette writes are done at acceptance, without leaving idle.
// Emit: three multiply-add passes, lattice read, palette read, output load; a pixel in an
//   unused tile skips the third pass and both reads; the load waits while the output
//   register is still held by the sink. Ignored cells and emits while unbuilt stay idle.
// Begin: a clearing pass over all lx*ly*lz lattice entries, one lattice entry a cycle.
// Reset (synchronous, active low) latches a 1x1x1 lattice and clears its one entry.
module voxel_label_downsample_atlas (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vlda_in_if.sink     i_in,
    vlda_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    // one-hot sequencer states
    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_CLEAR   = 12'b0000_0000_0010,
        S_SRC_A   = 12'b0000_0000_0100,
        S_SRC_B   = 12'b0000_0000_1000,
        S_SRC_RD  = 12'b0000_0001_0000,
        S_SRC_WR  = 12'b0000_0010_0000,
        S_PIX_A   = 12'b0000_0100_0000,
        S_PIX_B   = 12'b0000_1000_0000,
        S_PIX_C   = 12'b0001_0000_0000,
        S_PIX_RD  = 12'b0010_0000_0000,
        S_PIX_PAL = 12'b0100_0000_0000,
        S_PIX_OUT = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [10:0] r_cfg_sx, r_cfg_sy, r_cfg_sz;
    logic [8:0]  r_pal_size;

    // latched geometry
    logic [10:0] r_sx, r_sy, r_sz;
    logic [6:0]  r_lx, r_ly;
    logic [5:0]  r_lz;
    logic [2:0]  r_tx, r_ty;
    logic        r_built, r_src_done;

    logic [10:0] n_sx, n_sy, n_sz;
    logic [5:0]  n_lz;
    logic [2:0]  n_tx;

    // clearing pass
    logic [vlda_pkg::LAT_AW-1:0] r_clr_addr;
    logic [6:0]  r_cx, r_cy;
    logic [5:0]  r_cz;
    logic        n_clr_end;

    // emit cursor
    logic [6:0]  r_ix, r_iy;
    logic [2:0]  r_tcol, r_trow;
    logic [9:0]  r_px, r_py;
    logic        n_row_end, n_last;

    // transaction and datapath
    vlda_pkg::t_in_item          r_item;
    logic                        n_accept;
    vlda_pkg::t_mac_req          n_mac;
    logic [vlda_pkg::LAT_AW-1:0] mac_res;
    logic                        r_hit;

    // stores
    logic [8:0]  r_lat_mem [0:vlda_pkg::LAT_DEPTH-1];
    logic [31:0] r_pal_mem [0:vlda_pkg::PAL_DEPTH-1];
    logic [8:0]  r_lat_q;
    logic [31:0] r_pal_q;
    logic [vlda_pkg::LAT_AW-1:0] n_lat_addr;
    logic        n_lat_we;
    logic [8:0]  n_lat_wdata;
    logic        n_pal_we;

    // output register
    logic                r_out_valid;
    vlda_pkg::t_out_item r_out;
    logic                n_out_load;
    logic [31:0]         n_colour;

    // axis trackers
    vlda_pkg::t_axis_ctl ctl_x, ctl_y, ctl_z;
    logic [6:0] bx, by, bz;
    logic       wrap_x, wrap_y, wrap_z;

    assign i_in.ready  = (r_state == S_IDLE);
    assign n_accept    = i_in.valid && i_in.ready;

    // clamp sizes and derive the lattice at begin
    assign n_sx = (i_in.item.action == vlda_pkg::ACT_BEGIN && r_cfg_sx > 11'(vlda_pkg::SRC_MAX))
                ? 11'(vlda_pkg::SRC_MAX) : r_cfg_sx;
    assign n_sy = (r_cfg_sy > 11'(vlda_pkg::SRC_MAX)) ? 11'(vlda_pkg::SRC_MAX) : r_cfg_sy;
    assign n_sz = (r_cfg_sz > 11'(vlda_pkg::SRC_MAX)) ? 11'(vlda_pkg::SRC_MAX) : r_cfg_sz;
    assign n_lz = (n_sz > 11'(vlda_pkg::LAT_Z)) ? 6'(vlda_pkg::LAT_Z) : 6'(n_sz);
    assign n_tx = vlda_pkg::f_tiles_x(n_lz);

    assign n_clr_end = (r_cx == r_lx - 7'd1) && (r_cy == r_ly - 7'd1) && (r_cz == r_lz - 6'd1);

    assign n_row_end = (r_ix == r_lx - 7'd1) && (r_tcol == r_tx - 3'd1);
    assign n_last    = n_row_end && (r_iy == r_ly - 7'd1) && (r_trow == r_ty - 3'd1);

    // axis trackers: reset to block zero through a clear, step on each source cell
    assign ctl_x.init = (r_state == S_CLEAR);
    assign ctl_y.init = (r_state == S_CLEAR);
    assign ctl_z.init = (r_state == S_CLEAR);
    assign ctl_x.step = (r_state == S_SRC_WR);
    assign ctl_y.step = (r_state == S_SRC_WR) && wrap_x;
    assign ctl_z.step = (r_state == S_SRC_WR) && wrap_x && wrap_y;

    vlda_axis u_axis_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_size(r_sx), .i_lat(r_lx),
        .i_ctl(ctl_x), .o_block(bx), .o_wrap(wrap_x)
    );
    vlda_axis u_axis_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_size(r_sy), .i_lat(r_ly),
        .i_ctl(ctl_y), .o_block(by), .o_wrap(wrap_y)
    );
    vlda_axis u_axis_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_size(r_sz), .i_lat(7'(r_lz)),
        .i_ctl(ctl_z), .o_block(bz), .o_wrap(wrap_z)
    );

    // shared multiply-add unit operand selection
    always_comb begin
        n_mac = '0;
        case (r_state)
            S_SRC_A: begin
                n_mac = '{en: 1'b1, a: 13'(bz), b: r_ly, c: by};
            end
            S_SRC_B: begin
                n_mac = '{en: 1'b1, a: mac_res[12:0], b: r_lx, c: bx};
            end
            S_PIX_A: begin
                n_mac = '{en: 1'b1, a: 13'(r_trow), b: 7'(r_tx), c: 7'(r_tcol)};
            end
            S_PIX_B: begin
                n_mac = '{en: 1'b1, a: mac_res[12:0], b: r_ly, c: r_iy};
            end
            S_PIX_C: begin
                n_mac = '{en: 1'b1, a: mac_res[12:0], b: r_lx, c: r_ix};
            end
            default: begin
                n_mac = '0;
            end
        endcase
    end

    vlda_mac u_mac (
        .i_clk(i_clk), .i_req(n_mac), .o_res(mac_res)
    );

    assign n_out_load = (r_state == S_PIX_OUT) && (!r_out_valid || o_out.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (n_accept) begin
                    case (i_in.item.action)
                        vlda_pkg::ACT_BEGIN: begin
                            if (n_sx != '0 && n_sy != '0 && n_sz != '0) n_state = S_CLEAR;
                        end
                        vlda_pkg::ACT_CELL: begin
                            if (r_built && !r_src_done) n_state = S_SRC_A;
                        end
                        vlda_pkg::ACT_EMIT: begin
                            if (r_built) n_state = S_PIX_A;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:   if (n_clr_end) n_state = S_IDLE;
            S_SRC_A:   n_state = S_SRC_B;
            S_SRC_B:   n_state = S_SRC_RD;
            S_SRC_RD:  n_state = S_SRC_WR;
            S_SRC_WR:  n_state = S_IDLE;
            S_PIX_A:   n_state = S_PIX_B;
            S_PIX_B:   n_state = (mac_res < vlda_pkg::LAT_AW'(r_lz)) ? S_PIX_C : S_PIX_OUT;
            S_PIX_C:   n_state = S_PIX_RD;
            S_PIX_RD:  n_state = S_PIX_PAL;
            S_PIX_PAL: n_state = S_PIX_OUT;
            S_PIX_OUT: if (n_out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sx   <= 11'd1;
            r_cfg_sy   <= 11'd1;
            r_cfg_sz   <= 11'd1;
            r_pal_size <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vlda_pkg::REG_SIZE_X: r_cfg_sx   <= i_cfg_data;
                vlda_pkg::REG_SIZE_Y: r_cfg_sy   <= i_cfg_data;
                vlda_pkg::REG_SIZE_Z: r_cfg_sz   <= i_cfg_data;
                vlda_pkg::REG_PAL_SZ: r_pal_size <= i_cfg_data[8:0];
                default:              r_pal_size <= r_pal_size;
            endcase
        end
    end

    // geometry, cursors and clear counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx       <= 11'd1;
            r_sy       <= 11'd1;
            r_sz       <= 11'd1;
            r_lx       <= 7'd1;
            r_ly       <= 7'd1;
            r_lz       <= 6'd1;
            r_tx       <= 3'd1;
            r_ty       <= 3'd1;
            r_built    <= 1'b1;
            r_src_done <= 1'b0;
            r_clr_addr <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_cz       <= '0;
            r_ix       <= '0;
            r_iy       <= '0;
            r_tcol     <= '0;
            r_trow     <= '0;
            r_px       <= '0;
            r_py       <= '0;
        end else begin
            if (n_accept && i_in.item.action == vlda_pkg::ACT_BEGIN) begin
                // latch geometry and rewind everything
                r_sx       <= n_sx;
                r_sy       <= n_sy;
                r_sz       <= n_sz;
                r_lx       <= (n_sx > 11'(vlda_pkg::LAT_XY)) ? 7'(vlda_pkg::LAT_XY) : 7'(n_sx);
                r_ly       <= (n_sy > 11'(vlda_pkg::LAT_XY)) ? 7'(vlda_pkg::LAT_XY) : 7'(n_sy);
                r_lz       <= n_lz;
                r_tx       <= n_tx;
                r_ty       <= vlda_pkg::f_tiles_y(n_lz, n_tx);
                r_built    <= (n_sx != '0 && n_sy != '0 && n_sz != '0);
                r_src_done <= 1'b0;
                r_clr_addr <= '0;
                r_cx       <= '0;
                r_cy       <= '0;
                r_cz       <= '0;
                r_ix       <= '0;
                r_iy       <= '0;
                r_tcol     <= '0;
                r_trow     <= '0;
                r_px       <= '0;
                r_py       <= '0;
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + vlda_pkg::LAT_AW'(1);
                if (r_cx == r_lx - 7'd1) begin
                    r_cx <= '0;
                    if (r_cy == r_ly - 7'd1) begin
                        r_cy <= '0;
                        r_cz <= r_cz + 6'd1;
                    end else begin
                        r_cy <= r_cy + 7'd1;
                    end
                end else begin
                    r_cx <= r_cx + 7'd1;
                end
            end
            if (r_state == S_SRC_WR && wrap_x && wrap_y && wrap_z) r_src_done <= 1'b1;
            if (n_out_load) begin
                // advance the atlas cursor, wrapping after the last pixel
                if (r_ix == r_lx - 7'd1) begin
                    r_ix <= '0;
                    if (r_tcol == r_tx - 3'd1) begin
                        r_tcol <= '0;
                        r_px   <= '0;
                        if (r_iy == r_ly - 7'd1) begin
                            r_iy <= '0;
                            if (r_trow == r_ty - 3'd1) begin
                                r_trow <= '0;
                                r_py   <= '0;
                            end else begin
                                r_trow <= r_trow + 3'd1;
                                r_py   <= r_py + 10'd1;
                            end
                        end else begin
                            r_iy <= r_iy + 7'd1;
                            r_py <= r_py + 10'd1;
                        end
                    end else begin
                        r_tcol <= r_tcol + 3'd1;
                        r_px   <= r_px + 10'd1;
                    end
                end else begin
                    r_ix <= r_ix + 7'd1;
                    r_px <= r_px + 10'd1;
                end
            end
        end
    end

    // transaction payload and hit flag
    always_ff @(posedge i_clk) begin
        if (n_accept) r_item <= i_in.item;
        if (r_state == S_PIX_B) r_hit <= 1'b0;
        if (r_state == S_PIX_PAL) begin
            r_hit <= r_lat_q[8] && (9'(r_lat_q[7:0]) < r_pal_size);
        end
    end

    // lattice store: clear sweep, read-modify-write of source cells, reads for emit
    assign n_lat_addr  = (r_state == S_CLEAR) ? r_clr_addr : mac_res;
    assign n_lat_we    = (r_state == S_CLEAR)
                      || (r_state == S_SRC_WR && r_item.room_valid && !r_lat_q[8]);
    assign n_lat_wdata = (r_state == S_CLEAR) ? 9'd0 : {1'b1, r_item.room_id};

    always_ff @(posedge i_clk) begin
        if (n_lat_we) r_lat_mem[n_lat_addr] <= n_lat_wdata;
        r_lat_q <= r_lat_mem[n_lat_addr];
    end

    // palette store: red in the low byte, alpha in the high byte
    assign n_pal_we = n_accept && (i_in.item.action == vlda_pkg::ACT_PAL);

    always_ff @(posedge i_clk) begin
        if (n_pal_we) begin
            r_pal_mem[i_in.item.palette_index] <= {i_in.item.color_alpha, i_in.item.color_blue,
                                                   i_in.item.color_green, i_in.item.color_red};
        end
        r_pal_q <= r_pal_mem[r_lat_q[7:0]];
    end

    // output register: drop the colour to black on a miss
    assign n_colour = r_hit ? r_pal_q : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_out.pixel_x    <= r_px;
            r_out.pixel_y    <= r_py;
            r_out.out_blue   <= n_colour[23:16];
            r_out.out_green  <= n_colour[15:8];
            r_out.out_red    <= n_colour[7:0];
            r_out.out_alpha  <= n_colour[31:24];
            r_out.last_pixel <= n_last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;
endmodule

### src/vlda_mac.sv
// Shared multiply-add unit with registered result.
module vlda_mac (
    input  logic                              i_clk,
    input  vlda_pkg::t_mac_req                i_req,
    output logic [vlda_pkg::LAT_AW-1:0]       o_res
);
    logic [vlda_pkg::LAT_AW-1:0] r_res;
    logic [19:0]                 n_prod;

    assign n_prod = 20'(i_req.a) * 20'(i_req.b) + 20'(i_req.c);

    always_ff @(posedge i_clk) begin
        if (i_req.en) r_res <= vlda_pkg::LAT_AW'(n_prod);
    end

    assign o_res = r_res;
endmodule

### src/vlda_axis.sv
// Incremental block index tracker for one source axis: q = ((c+1)*L-1)/S.
module vlda_axis (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [10:0]         i_size,
    input  logic [6:0]          i_lat,
    input  vlda_pkg::t_axis_ctl i_ctl,
    output logic [6:0]          o_block,
    output logic                o_wrap
);
    logic [9:0]  r_c;
    logic [9:0]  r_r;
    logic [6:0]  r_q;
    logic [10:0] n_sum;

    assign n_sum  = 11'(r_r) + 11'(i_lat);
    assign o_wrap = ((11'(r_c) + 11'd1) == i_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
            r_r <= '0;
            r_q <= '0;
        end else if (i_ctl.init || (i_ctl.step && o_wrap)) begin
            r_c <= '0;
            r_r <= 10'(i_lat) - 10'd1;
            r_q <= '0;
        end else if (i_ctl.step) begin
            r_c <= r_c + 10'd1;
            if (n_sum >= i_size) begin
                r_r <= 10'(n_sum - i_size);
                r_q <= r_q + 7'd1;
            end else begin
                r_r <= 10'(n_sum);
            end
        end
    end

    assign o_block = r_q;
endmodule

### bench/testbench.sv
// Self-checking testbench for the voxel label downsampler with slice-atlas output.
module testbench;

    localparam int unsigned WATCHDOG_LIMIT = 60000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned ITEM_TARGET    = 600;

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;

    typedef struct {
        t_row_kind           kind;
        vlda_pkg::t_reg_idx  reg_idx;
        logic [10:0]         reg_val;
        vlda_pkg::t_in_item  item;
        logic                typed;
        vlda_pkg::t_out_item typed_res;
    } t_stim_row;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    vlda_in_if  in_ch ();
    vlda_out_if out_ch ();

    voxel_label_downsample_atlas dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Free-running clock, period 12.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Atlas predictor: own copy of registers, lattice, palette and cursors
    // ------------------------------------------------------------------
    logic [10:0] reg_sx, reg_sy, reg_sz;
    logic [8:0]  reg_pal;
    logic [8:0]  lattice_q [vlda_pkg::LAT_DEPTH];
    logic [31:0] palette_q [vlda_pkg::PAL_DEPTH];   // {alpha, blue, green, red}
    int unsigned sx, sy, sz, lx, ly, lz, tiles_x, atlas_w, atlas_h;
    int unsigned cur_x, cur_y, cur_z, pixel_pos;
    bit          lat_built, grid_done;
    int unsigned clear_wait;
    logic [7:0]  written_ids [$];         // palette entries safe to reference
    bit          id_written [vlda_pkg::PAL_DEPTH];

    vlda_pkg::t_out_item pixel_q [$];     // pixels still owed by the block
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned src_idle_pct, snk_stall_pct;
    bit          hold_req;

    function automatic int unsigned block_idx(int unsigned c, int unsigned lat,
                                              int unsigned src);
        return ((c + 1) * lat - 1) / src;
    endfunction

    function automatic int unsigned clamp_dim(logic [10:0] v);
        return (v > vlda_pkg::SRC_MAX) ? vlda_pkg::SRC_MAX : int'(v);
    endfunction

    function automatic void rebuild_lattice();
        int unsigned ty;
        cur_x = 0; cur_y = 0; cur_z = 0;
        pixel_pos = 0;
        grid_done = 0;
        sx = clamp_dim(reg_sx);
        sy = clamp_dim(reg_sy);
        sz = clamp_dim(reg_sz);
        lat_built = (sx != 0 && sy != 0 && sz != 0);
        clear_wait = 0;
        if (!lat_built) return;
        lx = (sx < vlda_pkg::LAT_XY) ? sx : vlda_pkg::LAT_XY;
        ly = (sy < vlda_pkg::LAT_XY) ? sy : vlda_pkg::LAT_XY;
        lz = (sz < vlda_pkg::LAT_Z) ? sz : vlda_pkg::LAT_Z;
        tiles_x = 1;
        while (tiles_x * tiles_x < lz) tiles_x++;
        ty = (lz + tiles_x - 1) / tiles_x;
        atlas_w = lx * tiles_x;
        atlas_h = ly * ty;
        clear_wait = lx * ly * lz;
        for (int unsigned i = 0; i < lx * ly * lz; i++) lattice_q[i] = '0;
    endfunction

    function automatic void accumulate_cell(logic v, logic [7:0] id);
        int unsigned idx;
        if (!lat_built || grid_done) return;
        idx = (block_idx(cur_z, lz, sz) * ly + block_idx(cur_y, ly, sy)) * lx
              + block_idx(cur_x, lx, sx);
        if (v && idx < vlda_pkg::LAT_DEPTH && !lattice_q[idx][8]) lattice_q[idx] = {1'b1, id};
        if (++cur_x >= sx) begin
            cur_x = 0;
            if (++cur_y >= sy) begin
                cur_y = 0;
                if (++cur_z >= sz) begin
                    cur_z = 0;
                    grid_done = 1;
                end
            end
        end
    endfunction

    function automatic vlda_pkg::t_out_item next_pixel();
        vlda_pkg::t_out_item r;
        int unsigned px, py, slice, idx, psz;
        logic [31:0] col;
        logic [8:0]  lab;
        bit          last;
        px = pixel_pos % atlas_w;
        py = pixel_pos / atlas_w;
        slice = (py / ly) * tiles_x + px / lx;
        col = '0;
        last = (pixel_pos + 1 >= atlas_w * atlas_h);
        if (slice < lz) begin
            idx = (slice * ly + py % ly) * lx + px % lx;
            lab = lattice_q[idx];
            psz = (reg_pal > vlda_pkg::PAL_DEPTH) ? vlda_pkg::PAL_DEPTH : int'(reg_pal);
            if (lab[8] && lab[7:0] < psz) col = palette_q[lab[7:0]];
        end
        r.pixel_x    = px[9:0];
        r.pixel_y    = py[9:0];
        r.out_blue   = col[23:16];
        r.out_green  = col[15:8];
        r.out_red    = col[7:0];
        r.out_alpha  = col[31:24];
        r.last_pixel = last;
        pixel_pos = last ? 0 : pixel_pos + 1;
        return r;
    endfunction

    // Advance the predictor by one accepted transaction; has_px flags a pixel.
    function automatic void predict_atlas(input vlda_pkg::t_in_item it, output bit has_px,
                                          output vlda_pkg::t_out_item px);
        has_px = 0;
        px = '0;
        case (vlda_pkg::t_action'(it.action))
            vlda_pkg::ACT_BEGIN: rebuild_lattice();
            vlda_pkg::ACT_CELL:  accumulate_cell(it.room_valid, it.room_id);
            vlda_pkg::ACT_PAL: begin
                palette_q[it.palette_index] = {it.color_alpha, it.color_blue,
                                               it.color_green, it.color_red};
                if (!id_written[it.palette_index]) begin
                    id_written[it.palette_index] = 1;
                    written_ids.push_back(it.palette_index);
                end
            end
            default: begin
                if (lat_built) begin
                    has_px = 1;
                    px = next_pixel();
                end
            end
        endcase
    endfunction

    function automatic vlda_pkg::t_in_item make_item(vlda_pkg::t_action act, logic v,
                                                     logic [7:0] id, logic [7:0] pidx,
                                                     logic [7:0] r, logic [7:0] g,
                                                     logic [7:0] b, logic [7:0] a);
        vlda_pkg::t_in_item it;
        it.action        = act;
        it.room_valid    = v;
        it.room_id       = id;
        it.palette_index = pidx;
        it.color_red     = r;
        it.color_green   = g;
        it.color_blue    = b;
        it.color_alpha   = a;
        return it;
    endfunction

    // Item with an action and nothing else.
    function automatic vlda_pkg::t_in_item bare_item(vlda_pkg::t_action act);
        return make_item(act, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endfunction

    // Source cell item.
    function automatic vlda_pkg::t_in_item cell_item(logic v, logic [7:0] id);
        return make_item(vlda_pkg::ACT_CELL, v, id, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endfunction

    // Random item of a given action; labels only ever point at written entries.
    function automatic vlda_pkg::t_in_item random_item(vlda_pkg::t_action act);
        vlda_pkg::t_in_item it;
        logic       v;
        logic [7:0] id;
        v = $urandom_range(0, 3) != 0;
        id = v ? written_ids[$urandom_range(0, written_ids.size() - 1)]
               : 8'($urandom);
        it = make_item(act, v, id, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driving side
    // ------------------------------------------------------------------
    task automatic send_item(input vlda_pkg::t_in_item it, input logic typed,
                             input vlda_pkg::t_out_item typed_res);
        bit                  has_px;
        vlda_pkg::t_out_item px;
        // idle the sender at random before offering the transaction
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.item  = it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
        predict_atlas(it, has_px, px);
        if (has_px) pixel_q.push_back(typed ? typed_res : px);
    endtask

    // Drop valid and wait until every owed pixel is out and any clear is done.
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (clear_wait + 60) @(posedge clk);
    endtask

    task automatic write_reg(input vlda_pkg::t_reg_idx idx, input logic [10:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            vlda_pkg::REG_SIZE_X: reg_sx  = val;
            vlda_pkg::REG_SIZE_Y: reg_sy  = val;
            vlda_pkg::REG_SIZE_Z: reg_sz  = val;
            default:              reg_pal = val[8:0];
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiving side: stall at random, or hold off for a long stretch
    // ------------------------------------------------------------------
    int unsigned hold_left;

    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            out_ch.ready = 1'b0;
            hold_left--;
        end else begin
            out_ch.ready = !(snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct);
        end
    end

    // Compare every pixel transaction against the oldest owed pixel.
    always @(posedge clk) begin
        vlda_pkg::t_out_item want, got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.item;
            if (pixel_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y);
            end else begin
                want = pixel_q.pop_front();
                if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                    got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
                    got.out_red !== want.out_red || got.out_alpha !== want.out_alpha ||
                    got.last_pixel !== want.last_pixel) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"pixel mismatch: want x=%0d y=%0d bgra=%h%h%h%h last=%b,",
                                  " got x=%0d y=%0d bgra=%h%h%h%h last=%b"},
                                 want.pixel_x, want.pixel_y, want.out_blue,
                                 want.out_green, want.out_red, want.out_alpha,
                                 want.last_pixel, got.pixel_x, got.pixel_y,
                                 got.out_blue, got.out_green, got.out_red,
                                 got.out_alpha, got.last_pixel);
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing at all is accepted.
    int unsigned quiet_cycles;

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // One random phase: program sizes and palette size, then a rebuild
    // sequence with random content and some noise mixed in.
    // ------------------------------------------------------------------
    task automatic run_phase(input int unsigned ph);
        int unsigned pick, n_cells, n_emit, n_pal;
        logic [10:0] dims [3];
        logic [8:0]  psz;
        vlda_pkg::t_out_item none;
        none = '0;
        case (ph % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 81; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 81; end
            default: begin src_idle_pct = 19; snk_stall_pct = 19; end
        endcase
        for (int i = 0; i < 3; i++) dims[i] = 11'($urandom_range(1, 4));
        pick = $urandom_range(0, 19);
        if (pick < 3) dims[pick] = 11'($urandom_range(97, 1024));
        else if (pick == 3) dims[$urandom_range(0, 2)] = 11'd1024;
        pick = $urandom_range(0, 9);
        psz = (pick == 0) ? 9'd0 : (pick == 1) ? 9'd256 : 9'($urandom_range(0, 256));

        settle();
        write_reg(vlda_pkg::REG_SIZE_X, dims[0]);
        write_reg(vlda_pkg::REG_SIZE_Y, dims[1]);
        write_reg(vlda_pkg::REG_SIZE_Z, dims[2]);
        write_reg(vlda_pkg::REG_PAL_SZ, 11'(psz));

        send_item(random_item(vlda_pkg::ACT_BEGIN), 1'b0, none);
        n_pal = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n_pal; i++)
            send_item(random_item(vlda_pkg::ACT_PAL), 1'b0, none);

        // full grid when small, then a few extra cells that must be ignored
        n_cells = sx * sy * sz;
        n_cells = (n_cells > 40) ? 40 : n_cells + $urandom_range(0, 2);
        for (int unsigned i = 0; i < n_cells; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(random_item(vlda_pkg::t_action'($urandom_range(0, 3))), 1'b0, none);
            send_item(random_item(vlda_pkg::ACT_CELL), 1'b0, none);
        end

        n_emit = lat_built ? atlas_w * atlas_h + 2 : 3;
        if (n_emit > 40) n_emit = 40;
        // hold the output off while the sender keeps pushing emits
        if (ph == 4) begin
            n_emit = 40;
            hold_req = 1;
        end
        for (int unsigned i = 0; i < n_emit; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(random_item(vlda_pkg::t_action'($urandom_range(0, 3))), 1'b0, none);
            send_item(random_item(vlda_pkg::ACT_EMIT), 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    t_stim_row rows [$];

    function automatic void row_cfg(vlda_pkg::t_reg_idx idx, logic [10:0] val);
        t_stim_row r;
        r.kind      = ROW_CFG;
        r.reg_idx   = idx;
        r.reg_val   = val;
        r.item      = '0;
        r.typed     = 1'b0;
        r.typed_res = '0;
        rows.push_back(r);
    endfunction

    function automatic void row_item(vlda_pkg::t_in_item it, logic typed,
                                     vlda_pkg::t_out_item res);
        t_stim_row r;
        r.kind      = ROW_ITEM;
        r.reg_idx   = vlda_pkg::REG_SIZE_X;
        r.reg_val   = '0;
        r.item      = it;
        r.typed     = typed;
        r.typed_res = res;
        rows.push_back(r);
    endfunction

    initial begin
        vlda_pkg::t_out_item none, first_px, black_px;
        int unsigned ph;
        none = '0;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.item = '0;
        out_ch.ready = 1'b0;
        hold_req = 0;
        hold_left = 0;
        quiet_cycles = 0;
        fail_count = 0;
        items_sent = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        foreach (id_written[i]) id_written[i] = 0;

        // register reset values and the 1x1x1 lattice latched by reset
        reg_sx = 11'd1; reg_sy = 11'd1; reg_sz = 11'd1; reg_pal = 9'd0;
        rebuild_lattice();

        // after reset: a single black pixel that is also the last one
        first_px = '{pixel_x: 10'd0, pixel_y: 10'd0, out_blue: 8'd0, out_green: 8'd0,
                     out_red: 8'd0, out_alpha: 8'd0, last_pixel: 1'b1};
        // palette size zero turns the sixth pixel of a 4x2 atlas black
        black_px = '{pixel_x: 10'd1, pixel_y: 10'd1, out_blue: 8'd0, out_green: 8'd0,
                     out_red: 8'd0, out_alpha: 8'd0, last_pixel: 1'b0};

        row_item(bare_item(vlda_pkg::ACT_EMIT), 1'b1, first_px);
        row_item(bare_item(vlda_pkg::ACT_EMIT), 1'b1, first_px);
        row_item(make_item(vlda_pkg::ACT_PAL, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00),
                 1'b0, none);
        row_item(make_item(vlda_pkg::ACT_PAL, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF),
                 1'b0, none);
        row_item(make_item(vlda_pkg::ACT_PAL, 1'b0, 8'h00, 8'hAA, 8'h12, 8'h34, 8'h56, 8'h78),
                 1'b0, none);
        row_cfg(vlda_pkg::REG_PAL_SZ, 11'd256);
        row_cfg(vlda_pkg::REG_SIZE_X, 11'd2);
        row_cfg(vlda_pkg::REG_SIZE_Y, 11'd2);
        row_cfg(vlda_pkg::REG_SIZE_Z, 11'd2);
        row_item(bare_item(vlda_pkg::ACT_BEGIN), 1'b0, none);
        row_item(cell_item(1'b1, 8'h00), 1'b0, none);
        row_item(cell_item(1'b1, 8'hFF), 1'b0, none);
        row_item(cell_item(1'b0, 8'hAA), 1'b0, none);
        row_item(cell_item(1'b1, 8'hAA), 1'b0, none);
        row_item(cell_item(1'b1, 8'h00), 1'b0, none);
        row_item(cell_item(1'b0, 8'h00), 1'b0, none);
        row_item(cell_item(1'b1, 8'hFF), 1'b0, none);
        row_item(cell_item(1'b1, 8'hAA), 1'b0, none);
        // grid complete: this one must be ignored
        row_item(cell_item(1'b1, 8'h00), 1'b0, none);
        for (int i = 0; i < 5; i++)
            row_item(bare_item(vlda_pkg::ACT_EMIT), 1'b0, none);
        row_cfg(vlda_pkg::REG_PAL_SZ, 11'd0);
        row_item(bare_item(vlda_pkg::ACT_EMIT), 1'b1, black_px);
        // a zero size leaves the block unbuilt: cells ignored, no pixel
        row_cfg(vlda_pkg::REG_SIZE_X, 11'd0);
        row_item(bare_item(vlda_pkg::ACT_BEGIN), 1'b0, none);
        row_item(cell_item(1'b1, 8'h00), 1'b0, none);
        row_item(bare_item(vlda_pkg::ACT_EMIT), 1'b0, none);
        // oversize source is clamped to the largest source dimension
        row_cfg(vlda_pkg::REG_SIZE_X, 11'd2047);
        row_cfg(vlda_pkg::REG_PAL_SZ, 11'd256);
        row_item(bare_item(vlda_pkg::ACT_BEGIN), 1'b0, none);
        row_item(bare_item(vlda_pkg::ACT_EMIT), 1'b0, none);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        // let the reset clear of the single lattice entry finish
        repeat (20) @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                send_item(rows[i].item, rows[i].typed, rows[i].typed_res);
            end
        end

        // random part: keep going until enough transactions and all modes seen
        ph = 0;
        while (items_sent < ITEM_TARGET || ph < 8) begin
            run_phase(ph);
            ph++;
        end

        settle();
        if (fail_count == 0 && pixel_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### voxel_label_downsample_atlas.f
src/vlda_pkg.sv
src/vlda_if.sv
src/vlda_mac.sv
src/vlda_axis.sv
src/voxel_label_downsample_atlas.sv
bench/testbench.sv
